// ===== rtl/dchm_pkg.sv =====
// Shared types, codes and pattern table of the drift chamber efficiency monitor.
`timescale 1ns / 1ps
package dchm_pkg;

	localparam int NPAT        = 8;
	localparam int PAT_W       = 7;
	localparam int CELL_ID_W   = 6;
	localparam int VIEW_W      = 16;
	localparam int CELL_HITS_W = 8;
	localparam int OCC_EXT_W   = 16;
	localparam int FRAC_BITS   = 16;
	localparam int EFF_W       = FRAC_BITS + 1;
	localparam int NRATIO      = 3;
	localparam int OP_W        = 2;

	localparam logic [OP_W-1:0] OP_HIT   = 2'd0;
	localparam logic [OP_W-1:0] OP_EOE   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] RATIO_ALL = 2'd0;
	localparam logic [1:0] RATIO_X   = 2'd1;
	localparam logic [1:0] RATIO_Y   = 2'd2;

	localparam logic [EFF_W-1:0] EFF_ONE = 17'h10000;
	localparam logic [OCC_EXT_W-1:0] CELL_HITS_MAX = 16'd255;

	// three pivot cells, then two probe pairs
	localparam logic [CELL_ID_W-1:0] PAT_CELLS [NPAT][PAT_W] = '{
		'{6'd0,  6'd12, 6'd24, 6'd7,  6'd6,  6'd19, 6'd18},
		'{6'd1,  6'd13, 6'd25, 6'd8,  6'd7,  6'd19, 6'd20},
		'{6'd7,  6'd19, 6'd31, 6'd12, 6'd13, 6'd24, 6'd25},
		'{6'd8,  6'd20, 6'd32, 6'd13, 6'd14, 6'd25, 6'd26},
		'{6'd4,  6'd16, 6'd28, 6'd10, 6'd9,  6'd22, 6'd21},
		'{6'd5,  6'd17, 6'd29, 6'd10, 6'd11, 6'd22, 6'd23},
		'{6'd9,  6'd21, 6'd33, 6'd15, 6'd16, 6'd27, 6'd28},
		'{6'd10, 6'd22, 6'd34, 6'd16, 6'd17, 6'd28, 6'd29}
	};

	typedef struct packed {
		logic [1:0]             pad;
		logic                   eff_y_valid;
		logic [EFF_W-1:0]       eff_y;
		logic                   eff_x_valid;
		logic [EFF_W-1:0]       eff_x;
		logic                   eff_all_valid;
		logic [EFF_W-1:0]       eff_all;
		logic [VIEW_W-1:0]      hits_x_view;
		logic [VIEW_W-1:0]      hits_y_view;
		logic [CELL_HITS_W-1:0] cell_hits;
	} result_t;

endpackage

// ===== rtl/dchm_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module dchm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/dchm_sub_cmp.sv =====
// Shared compare-subtract unit used for ratio checks and restoring division steps.
`timescale 1ns / 1ps
module dchm_sub_cmp #(
	parameter int W = 36
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         ge,
	output logic [W-1:0] diff
);

	logic [W:0] d;

	assign d    = {1'b0, a} - {1'b0, b};
	assign ge   = ~d[W];
	assign diff = d[W-1:0];

endmodule

// ===== rtl/drift_chamber_hit_efficiency_monitor_unit.sv =====
// Top level of the drift chamber hit occupancy and efficiency monitor.
`timescale 1ns / 1ps
// A hit transaction is one occupancy RAM read, then the saturating write back
// with the result, which waits until the output register is free. Clear and
// other transactions go straight to the result. An end-of-event transaction
// evaluates the 8 patterns one by one, then three probe/pivot ratios, each a
// load, a check and, unless the check settles it, 16 restoring division steps
// on the one shared compare-subtract unit, then the result. The input is not
// ready while a transaction is in progress; a result waits in the output register without blocking the next input.
module drift_chamber_hit_efficiency_monitor_unit
	import dchm_pkg::*;
#(
	parameter int NUM_CELLS = 36,
	parameter int OCC_BITS  = 8,
	parameter int ACC_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // cell_id[5:0], view[6], zero[7]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // cell_hits, hits_y_view, hits_x_view, eff_all,
	                               // eff_all_valid, eff_x, eff_x_valid, eff_y,
	                               // eff_y_valid, zero pad
);

	localparam int CELL_IW = $clog2(NUM_CELLS);
	localparam int SUM_W   = ACC_BITS + 2;
	localparam int DIV_W   = ACC_BITS + 3;
	localparam int K_W     = $clog2(NPAT);
	localparam int STEP_W  = $clog2(FRAC_BITS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_HIT, ST_PAT, ST_LOAD, ST_CHECK, ST_DIV, ST_DONE
	} state_t;

	state_t                  state_q;
	logic [OP_W-1:0]         op_q;
	logic [CELL_IW-1:0]      cell_q;
	logic                    view_q;
	logic [NUM_CELLS-1:0]    occ_valid_q;
	logic [VIEW_W-1:0]       y_cnt_q, x_cnt_q;
	logic [ACC_BITS-1:0]     pivot_q [NPAT];
	logic [ACC_BITS-1:0]     probe_q [NPAT];
	logic [K_W-1:0]          k_q;
	logic [SUM_W-1:0]        piv_y_q, piv_x_q, prb_y_q, prb_x_q;
	logic [1:0]              sel_q;
	logic [DIV_W-1:0]        num_q, den_q, rem_q;
	logic [FRAC_BITS-1:0]    quo_q;
	logic [STEP_W-1:0]       step_q;
	logic [EFF_W-1:0]        eff_q [NRATIO];
	logic [NRATIO-1:0]       effv_q;
	result_t                 result_q;
	logic                    m_tvalid_q;

	logic                    accept, out_free, in_range, res_load;
	logic [OP_W-1:0]         op_in;
	logic [CELL_ID_W-1:0]    cell_in;
	logic                    view_in;
	logic                    ram_re, ram_we;
	logic [OCC_BITS-1:0]     occ_rdata, occ_old, occ_new;
	logic [OCC_BITS:0]       occ_sum;
	logic [OCC_EXT_W-1:0]    occ_ext;
	logic [VIEW_W-1:0]       y_inc, x_inc;
	logic                    fire;
	logic [1:0]              probe_inc;
	logic [ACC_BITS-1:0]     piv_new, prb_new;
	logic [DIV_W-1:0]        num_sel, den_sel;
	logic [DIV_W:0]          cmp_a, cmp_b, cmp_diff;
	logic                    cmp_ge;
	logic [FRAC_BITS-1:0]    quo_next;
	result_t                 res_hit, res_done;

	function automatic logic [ACC_BITS-1:0] acc_add(input logic [ACC_BITS-1:0] a,
	                                                input logic [1:0] b);
		logic [ACC_BITS:0] s;
		s = {1'b0, a} + (ACC_BITS+1)'(b);
		return s[ACC_BITS] ? {ACC_BITS{1'b1}} : s[ACC_BITS-1:0];
	endfunction

	function automatic logic occ(input logic [NUM_CELLS-1:0] v,
	                             input logic [CELL_ID_W-1:0] c);
		return v[c[CELL_IW-1:0]];
	endfunction

	assign op_in    = s_tuser;
	assign cell_in  = s_tdata[CELL_ID_W-1:0];
	assign view_in  = s_tdata[CELL_ID_W];
	assign in_range = (7'(cell_in) < 7'(NUM_CELLS));
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign res_load = out_free && ((state_q == ST_HIT) || (state_q == ST_DONE));
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = result_q;

	// occupancy store
	assign ram_re = accept && (op_in == OP_HIT) && in_range;
	assign ram_we = (state_q == ST_HIT) && out_free;

	dchm_ram #(.WIDTH(OCC_BITS), .DEPTH(NUM_CELLS)) u_occ_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cell_q),
		.wdata (occ_new),
		.re    (ram_re),
		.raddr (cell_in[CELL_IW-1:0]),
		.rdata (occ_rdata)
	);

	always_comb begin
		occ_old = occ_valid_q[cell_q] ? occ_rdata : '0;
		occ_sum = {1'b0, occ_old} + (OCC_BITS+1)'(1);
		occ_new = occ_sum[OCC_BITS] ? {OCC_BITS{1'b1}} : occ_sum[OCC_BITS-1:0];
		occ_ext = OCC_EXT_W'(occ_new);
		y_inc   = (&y_cnt_q) ? y_cnt_q : y_cnt_q + VIEW_W'(1);
		x_inc   = (&x_cnt_q) ? x_cnt_q : x_cnt_q + VIEW_W'(1);
	end

	// pattern evaluation for pattern k_q
	always_comb begin
		fire = occ(occ_valid_q, PAT_CELLS[k_q][0]) && occ(occ_valid_q, PAT_CELLS[k_q][1])
		    && occ(occ_valid_q, PAT_CELLS[k_q][2]);
		probe_inc = 2'((occ(occ_valid_q, PAT_CELLS[k_q][3])
		                || occ(occ_valid_q, PAT_CELLS[k_q][4])))
		          + 2'((occ(occ_valid_q, PAT_CELLS[k_q][5])
		                || occ(occ_valid_q, PAT_CELLS[k_q][6])));
		piv_new = fire ? acc_add(pivot_q[k_q], 2'd2) : pivot_q[k_q];
		prb_new = fire ? acc_add(probe_q[k_q], probe_inc) : probe_q[k_q];
	end

	// ratio operand selection
	always_comb begin
		unique case (sel_q)
			RATIO_ALL: begin
				num_sel = DIV_W'(prb_x_q) + DIV_W'(prb_y_q);
				den_sel = DIV_W'(piv_x_q) + DIV_W'(piv_y_q);
			end
			RATIO_X: begin
				num_sel = DIV_W'(prb_x_q);
				den_sel = DIV_W'(piv_x_q);
			end
			default: begin
				num_sel = DIV_W'(prb_y_q);
				den_sel = DIV_W'(piv_y_q);
			end
		endcase
	end

	assign cmp_a = (state_q == ST_DIV) ? {rem_q, 1'b0} : {1'b0, num_q};
	assign cmp_b = {1'b0, den_q};

	dchm_sub_cmp #(.W(DIV_W + 1)) u_sub_cmp (
		.a    (cmp_a),
		.b    (cmp_b),
		.ge   (cmp_ge),
		.diff (cmp_diff)
	);

	assign quo_next = {quo_q[FRAC_BITS-2:0], cmp_ge};

	always_comb begin
		res_hit             = '0;
		res_hit.cell_hits   = (occ_ext > CELL_HITS_MAX) ? {CELL_HITS_W{1'b1}}
		                                                : occ_ext[CELL_HITS_W-1:0];
		res_hit.hits_y_view = view_q ? y_cnt_q : y_inc;
		res_hit.hits_x_view = view_q ? x_inc : x_cnt_q;

		res_done             = '0;
		res_done.hits_y_view = y_cnt_q;
		res_done.hits_x_view = x_cnt_q;
		if (op_q == OP_EOE) begin
			res_done.eff_all       = eff_q[RATIO_ALL];
			res_done.eff_all_valid = effv_q[RATIO_ALL];
			res_done.eff_x         = eff_q[RATIO_X];
			res_done.eff_x_valid   = effv_q[RATIO_X];
			res_done.eff_y         = eff_q[RATIO_Y];
			res_done.eff_y_valid   = effv_q[RATIO_Y];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_tvalid_q  <= 1'b0;
			occ_valid_q <= '0;
			y_cnt_q     <= '0;
			x_cnt_q     <= '0;
			for (int i = 0; i < NPAT; i++) begin
				pivot_q[i] <= '0;
				probe_q[i] <= '0;
			end
		end else begin
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q   <= op_in;
						cell_q <= cell_in[CELL_IW-1:0];
						view_q <= view_in;
						if (op_in == OP_HIT && in_range) begin
							state_q <= ST_HIT;
						end else if (op_in == OP_EOE) begin
							state_q <= ST_PAT;
							k_q     <= '0;
							piv_y_q <= '0;
							piv_x_q <= '0;
							prb_y_q <= '0;
							prb_x_q <= '0;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_HIT: begin
					if (out_free) begin
						occ_valid_q[cell_q] <= 1'b1;
						if (view_q) begin
							x_cnt_q <= x_inc;
						end else begin
							y_cnt_q <= y_inc;
						end
						result_q <= res_hit;
						state_q  <= ST_IDLE;
					end
				end
				ST_PAT: begin
					pivot_q[k_q] <= piv_new;
					probe_q[k_q] <= prb_new;
					if (k_q[K_W-1]) begin
						piv_x_q <= piv_x_q + SUM_W'(piv_new);
						prb_x_q <= prb_x_q + SUM_W'(prb_new);
					end else begin
						piv_y_q <= piv_y_q + SUM_W'(piv_new);
						prb_y_q <= prb_y_q + SUM_W'(prb_new);
					end
					k_q <= k_q + K_W'(1);
					if (k_q == K_W'(NPAT - 1)) begin
						sel_q   <= RATIO_ALL;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					num_q   <= num_sel;
					den_q   <= den_sel;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					priority if (den_q == '0) begin
						eff_q[sel_q]  <= '0;
						effv_q[sel_q] <= 1'b0;
						sel_q         <= sel_q + 2'd1;
						state_q       <= (sel_q == RATIO_Y) ? ST_DONE : ST_LOAD;
					end else if (cmp_ge) begin
						eff_q[sel_q]  <= EFF_ONE;
						effv_q[sel_q] <= 1'b1;
						sel_q         <= sel_q + 2'd1;
						state_q       <= (sel_q == RATIO_Y) ? ST_DONE : ST_LOAD;
					end else begin
						rem_q   <= num_q;
						quo_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= cmp_ge ? cmp_diff[DIV_W-1:0] : cmp_a[DIV_W-1:0];
					quo_q  <= quo_next;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(FRAC_BITS - 1)) begin
						eff_q[sel_q]  <= EFF_W'(quo_next);
						effv_q[sel_q] <= 1'b1;
						sel_q         <= sel_q + 2'd1;
						state_q       <= (sel_q == RATIO_Y) ? ST_DONE : ST_LOAD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						result_q <= res_done;
						state_q  <= ST_IDLE;
						if (op_q == OP_EOE) begin
							occ_valid_q <= '0;
							y_cnt_q     <= '0;
							x_cnt_q     <= '0;
						end
						if (op_q == OP_CLEAR) begin
							for (int i = 0; i < NPAT; i++) begin
								pivot_q[i] <= '0;
								probe_q[i] <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/dchm_checker.sv =====
// Port-level assertions for the drift chamber efficiency monitor, bound to the top.
`timescale 1ns / 1ps
module dchm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	// input not ready in the cycle after each input transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transaction");

	a_eff_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[57] || m_tdata[56:40] == 17'd0)
		          && (m_tdata[75] || m_tdata[74:58] == 17'd0)
		          && (m_tdata[93] || m_tdata[92:76] == 17'd0))
		else $error("invalid ratio with nonzero value");

	a_eff_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[56:40] <= 17'h10000 && m_tdata[74:58] <= 17'h10000
		          && m_tdata[92:76] <= 17'h10000 && m_tdata[95:94] == 2'b00)
		else $error("ratio above one or pad bits set");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind drift_chamber_hit_efficiency_monitor_unit dchm_checker u_dchm_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the drift chamber hit occupancy and efficiency monitor.
`timescale 1ns / 1ps
module tb_top;
	import dchm_pkg::*;

	localparam int N_CELLS = 36;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 100;
	localparam int HOLD_CYCLES = 300;
	localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
	localparam logic [31:0] ACC_MAX = 32'hFFFF_FFFF;

	// per pattern: three pivot cells, then two probe pairs
	localparam logic [5:0] PATTERN_MAP [8][7] = '{
		'{6'd0,  6'd12, 6'd24, 6'd7,  6'd6,  6'd19, 6'd18},
		'{6'd1,  6'd13, 6'd25, 6'd8,  6'd7,  6'd19, 6'd20},
		'{6'd7,  6'd19, 6'd31, 6'd12, 6'd13, 6'd24, 6'd25},
		'{6'd8,  6'd20, 6'd32, 6'd13, 6'd14, 6'd25, 6'd26},
		'{6'd4,  6'd16, 6'd28, 6'd10, 6'd9,  6'd22, 6'd21},
		'{6'd5,  6'd17, 6'd29, 6'd10, 6'd11, 6'd22, 6'd23},
		'{6'd9,  6'd21, 6'd33, 6'd15, 6'd16, 6'd27, 6'd28},
		'{6'd10, 6'd22, 6'd34, 6'd16, 6'd17, 6'd28, 6'd29}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;

	drift_chamber_hit_efficiency_monitor_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// predicted chamber state
	logic [7:0] occ_cnt [N_CELLS];
	logic [15:0] y_hits;
	logic [15:0] x_hits;
	logic [31:0] piv_acc [8];
	logic [31:0] prb_acc [8];

	result_t pending_reports[$];

	int src_idle_pct = 33;
	int snk_idle_pct = 74;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int n_items = 0;
	int n_checked = 0;
	int n_eoe = 0;
	int n_fired = 0;
	int n_err = 0;
	int stall_cycles = 0;

	function automatic logic [EFF_W:0] eff_ratio(input longint unsigned num,
			input longint unsigned den);
		logic [EFF_W-1:0] q;
		if (den == 0)
			return '0;
		if (num >= den)
			q = EFF_ONE;
		else
			q = EFF_W'((num << FRAC_BITS) / den);
		return {1'b1, q};
	endfunction

	function automatic bit occupied(input logic [5:0] c);
		return (c < N_CELLS) && (occ_cnt[c] != 0);
	endfunction

	function automatic result_t predict_report(input logic [1:0] op, input logic [5:0] cid,
			input logic v);
		result_t r;
		longint unsigned py, px, qy, qx;
		logic [EFF_W:0] rr;
		int inc;
		r = '0;
		case (op)
			OP_HIT: begin
				if (cid < N_CELLS) begin
					if (occ_cnt[cid] != 8'hFF)
						occ_cnt[cid]++;
					if (v) begin
						if (x_hits != 16'hFFFF)
							x_hits++;
					end else begin
						if (y_hits != 16'hFFFF)
							y_hits++;
					end
					r.cell_hits = occ_cnt[cid];
				end
			end
			OP_EOE: begin
				n_eoe++;
				for (int k = 0; k < 8; k++) begin
					if (occupied(PATTERN_MAP[k][0]) && occupied(PATTERN_MAP[k][1]) &&
							occupied(PATTERN_MAP[k][2])) begin
						n_fired++;
						piv_acc[k] = (piv_acc[k] > ACC_MAX - 2) ? ACC_MAX : piv_acc[k] + 2;
						inc = 0;
						if (occupied(PATTERN_MAP[k][3]) || occupied(PATTERN_MAP[k][4]))
							inc++;
						if (occupied(PATTERN_MAP[k][5]) || occupied(PATTERN_MAP[k][6]))
							inc++;
						prb_acc[k] = (prb_acc[k] > ACC_MAX - inc) ? ACC_MAX : prb_acc[k] + inc;
					end
				end
				py = 0;
				px = 0;
				qy = 0;
				qx = 0;
				for (int k = 0; k < 4; k++) begin
					py += piv_acc[k];
					qy += prb_acc[k];
					px += piv_acc[k + 4];
					qx += prb_acc[k + 4];
				end
				rr = eff_ratio(qx + qy, px + py);
				{r.eff_all_valid, r.eff_all} = rr;
				rr = eff_ratio(qx, px);
				{r.eff_x_valid, r.eff_x} = rr;
				rr = eff_ratio(qy, py);
				{r.eff_y_valid, r.eff_y} = rr;
			end
			OP_CLEAR: begin
				for (int k = 0; k < 8; k++) begin
					piv_acc[k] = '0;
					prb_acc[k] = '0;
				end
			end
			default: ;
		endcase
		r.hits_y_view = y_hits;
		r.hits_x_view = x_hits;
		if (op == OP_EOE) begin
			for (int c = 0; c < N_CELLS; c++)
				occ_cnt[c] = '0;
			y_hits = '0;
			x_hits = '0;
		end
		return r;
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [5:0] cid, input logic v);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, v, cid};
		s_tuser <= op;
		do
			@(posedge clk);
		while (!s_tready);
		pending_reports.push_back(predict_report(op, cid, v));
		n_items++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(input string fname, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			n_err++;
			if (n_err <= 10)
				$display("mismatch on result %0d, %s: expected %0d, got %0d",
					n_checked, fname, want, got);
		end
	endtask

	// receiver: random backpressure, or a forced hold-off stretch
	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata);
			if (pending_reports.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected transaction on output: %h", m_tdata);
			end else begin
				want = pending_reports.pop_front();
				check_field("cell_hits", want.cell_hits, got.cell_hits);
				check_field("hits_y_view", want.hits_y_view, got.hits_y_view);
				check_field("hits_x_view", want.hits_x_view, got.hits_x_view);
				check_field("eff_all", want.eff_all, got.eff_all);
				check_field("eff_all_valid", want.eff_all_valid, got.eff_all_valid);
				check_field("eff_x", want.eff_x, got.eff_x);
				check_field("eff_x_valid", want.eff_x_valid, got.eff_x_valid);
				check_field("eff_y", want.eff_y, got.eff_y);
				check_field("eff_y_valid", want.eff_y_valid, got.eff_y_valid);
				check_field("pad", 0, got.pad);
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic test_directed();
		send_item(OP_EOE, 6'd0, 1'b0);
		send_item(OP_HIT, 6'd0, 1'b0);
		send_item(OP_HIT, 6'd63, 1'b1);
		send_item(OP_HIT, 6'd36, 1'b0);
		send_item(OP_HIT, 6'd35, 1'b1);
		send_item(OP_UNDEF, 6'd63, 1'b1);
		// pattern 0 with one probe pair
		send_item(OP_HIT, 6'd12, 1'b1);
		send_item(OP_HIT, 6'd24, 1'b0);
		send_item(OP_HIT, 6'd7, 1'b1);
		send_item(OP_EOE, 6'd63, 1'b1);
		// pattern 4 with both probe pairs
		send_item(OP_HIT, 6'd4, 1'b1);
		send_item(OP_HIT, 6'd16, 1'b1);
		send_item(OP_HIT, 6'd28, 1'b0);
		send_item(OP_HIT, 6'd10, 1'b1);
		send_item(OP_HIT, 6'd22, 1'b0);
		send_item(OP_EOE, 6'd0, 1'b0);
		send_item(OP_CLEAR, 6'd63, 1'b1);
		send_item(OP_HIT, 6'd0, 1'b0);
		send_item(OP_HIT, 6'd0, 1'b0);
		send_item(OP_EOE, 6'd0, 1'b0);
		send_item(OP_CLEAR, 6'd0, 1'b0);
	endtask

	task automatic test_random_events(input int budget);
		int first;
		int sel;
		logic [5:0] cells[$];
		first = n_items;
		while (n_items - first < budget) begin
			sel = $urandom_range(0, 99);
			cells.delete();
			if (sel < 78) begin
				for (int k = 0; k < 8; k++) begin
					if ($urandom_range(0, 99) < 40) begin
						for (int j = 0; j < 3; j++)
							cells.push_back(PATTERN_MAP[k][j]);
						for (int j = 3; j < 7; j++)
							if ($urandom_range(0, 1))
								cells.push_back(PATTERN_MAP[k][j]);
					end
				end
				repeat ($urandom_range(0, 4))
					cells.push_back(6'($urandom_range(0, N_CELLS - 1)));
				// sometimes a pattern just misses
				if (cells.size() > 0 && $urandom_range(0, 3) == 0)
					cells.delete($urandom_range(0, cells.size() - 1));
				for (int i = 0; i < cells.size(); i++)
					send_item(OP_HIT, cells[i], 1'($urandom_range(0, 1)));
				send_item(OP_EOE, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			end else if (sel < 88) begin
				repeat ($urandom_range(1, 3))
					send_item(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
						1'($urandom_range(0, 1)));
			end else if (sel < 95) begin
				repeat ($urandom_range(1, 4))
					send_item(OP_HIT, 6'($urandom_range(N_CELLS, 63)),
						1'($urandom_range(0, 1)));
				send_item(OP_EOE, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			end else begin
				send_item(OP_CLEAR, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic test_backpressure();
		hold_reqs++;
		repeat (40)
			send_item(OP_HIT, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
		send_item(OP_EOE, 6'd0, 1'b1);
		wait_drained();
	endtask

	// drives one cell counter past its limit
	task automatic test_saturation();
		for (int i = 0; i < 260; i++)
			send_item(OP_HIT, 6'd35, 1'($urandom_range(0, 1)));
		send_item(OP_EOE, 6'd35, 1'b0);
	endtask

	initial begin
		for (int c = 0; c < N_CELLS; c++)
			occ_cnt[c] = '0;
		for (int k = 0; k < 8; k++) begin
			piv_acc[k] = '0;
			prb_acc[k] = '0;
		end
		y_hits = '0;
		x_hits = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 33;
		snk_idle_pct = 74;
		test_directed();
		test_random_events(100);

		src_idle_pct = 74;
		snk_idle_pct = 33;
		test_random_events(100);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_backpressure();
		test_random_events(100);
		test_saturation();

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("summary: %0d items sent, %0d results checked, %0d events evaluated,",
			n_items, n_checked, n_eoe);
		$display("summary: %0d pivot patterns fired, %0d mismatches", n_fired, n_err);
		if (n_err == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dchm_pkg.sv
rtl/dchm_ram.sv
rtl/dchm_sub_cmp.sv
rtl/drift_chamber_hit_efficiency_monitor_unit.sv
rtl/dchm_checker.sv
tb/sv/tb_top.sv
